@@ design/dfst_pkg.sv @@
// shared types and constants for the deauth frame source tracker
`timescale 1ns / 1ps

package dfst_pkg;

  localparam int DEF_TABLE_ENTRIES = 6;
  localparam int QUEUE_DEPTH       = 2;
  localparam int QPTR_W            = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W  = 48;
  localparam int RSSI_W  = 8;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int TOTAL_W = 32;
  localparam int SLOT_W  = 3;
  localparam int USED_W  = 3;

  localparam logic [3:0] SUBTYPE_DEAUTH   = 4'hC;
  localparam logic [3:0] SUBTYPE_DISASSOC = 4'hA;

  typedef enum logic [1:0] {
    ACT_IGNORED = 2'd0,
    ACT_HIT     = 2'd1,
    ACT_FREE    = 2'd2,
    ACT_EVICT   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_SCAN,
    BK_WRITE
  } back_state_t;

  typedef struct packed {
    logic                     counted;
    logic [ADDR_W-1:0]        bssid;
    logic signed [RSSI_W-1:0] rssi;
    logic [TIME_W-1:0]        now_ms;
  } frame_item_t;

endpackage

@@ design/dfst_front.sv @@
// front end: accepts frames and classifies them as counted or ignored
`timescale 1ns / 1ps

module dfst_front import dfst_pkg::*; (
  input  logic                     start,
  input  logic                     busy,
  input  logic                     is_mgmt,
  input  logic [7:0]               frame_ctrl,
  input  logic [ADDR_W-1:0]        bssid,
  input  logic signed [RSSI_W-1:0] rssi,
  input  logic [TIME_W-1:0]        now_ms,
  output logic                     push,
  output frame_item_t              item
);

  logic [3:0] subtype;
  logic       counted;

  assign subtype = frame_ctrl[7:4];

  always_comb begin
    unique case (subtype) inside
      SUBTYPE_DEAUTH, SUBTYPE_DISASSOC: counted = is_mgmt;
      default:                          counted = 1'b0;
    endcase
  end

  assign push         = start && !busy;
  assign item.counted = counted;
  assign item.bssid   = bssid;
  assign item.rssi    = rssi;
  assign item.now_ms  = now_ms;

endmodule

@@ design/dfst_queue.sv @@
// short frame queue between the front end and the table engine
`timescale 1ns / 1ps

module dfst_queue import dfst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_item_t push_item,
  input  logic        pop,
  output logic        full,
  output logic        valid,
  output frame_item_t head
);

  frame_item_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign valid = (fill != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ design/dfst_back.sv @@
// table engine: bssid lookup, free entry fill, oldest entry eviction, results
`timescale 1ns / 1ps

module dfst_back import dfst_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  frame_item_t        q_head,
  output logic               pop,
  output logic               done,
  output logic [1:0]         action,
  output logic [SLOT_W-1:0]  slot,
  output logic [COUNT_W-1:0] entry_count,
  output logic [TOTAL_W-1:0] frames_total,
  output logic [USED_W-1:0]  entries_used
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [ADDR_W-1:0]        entry_address  [TABLE_ENTRIES];
  logic [COUNT_W-1:0]       entry_frames   [TABLE_ENTRIES];
  logic signed [RSSI_W-1:0] entry_strength [TABLE_ENTRIES];
  logic [TIME_W-1:0]        entry_heard_at [TABLE_ENTRIES];

  back_state_t        state;
  back_state_t        state_next;
  frame_item_t        cur;
  logic [CNT_W-1:0]   occupied;
  logic [TOTAL_W-1:0] total;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   best_idx;
  logic [TIME_W-1:0]  best_time;

  logic [TABLE_ENTRIES-1:0] match;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic                     has_free;
  logic                     scan_last;
  logic                     scan_better;

  logic               take;
  logic               scan_start;
  logic               scan_step;
  logic               occ_inc;
  logic               wr_en;
  logic               wr_fresh;
  logic [IDX_W-1:0]   wr_idx;
  logic [COUNT_W-1:0] wr_count;
  logic               res_en;
  action_t            res_action;
  logic [IDX_W-1:0]   res_slot;
  logic [COUNT_W-1:0] res_count;
  logic [CNT_W-1:0]   res_occ;

  // parallel address compare over occupied entries
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = (CNT_W'(i) < occupied) && (entry_address[i] == cur.bssid);
    end
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign has_free    = (occupied < CNT_W'(TABLE_ENTRIES));
  assign scan_last   = (scan_idx == IDX_W'(TABLE_ENTRIES - 1));
  assign scan_better = (entry_heard_at[scan_idx] < best_time);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && q_head.counted) begin
          state_next = BK_LOOKUP;
        end
      end
      BK_LOOKUP: begin
        if (hit || has_free) begin
          state_next = BK_IDLE;
        end else if (TABLE_ENTRIES == 1) begin
          state_next = BK_WRITE;
        end else begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_last) begin
          state_next = BK_WRITE;
        end
      end
      BK_WRITE: state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    pop        = 1'b0;
    take       = 1'b0;
    scan_start = 1'b0;
    scan_step  = 1'b0;
    occ_inc    = 1'b0;
    wr_en      = 1'b0;
    wr_fresh   = 1'b0;
    wr_idx     = '0;
    wr_count   = '0;
    res_en     = 1'b0;
    res_action = ACT_IGNORED;
    res_slot   = '0;
    res_count  = '0;
    res_occ    = occupied;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_head.counted) begin
            take = 1'b1;
          end else begin
            res_en = 1'b1;
          end
        end
      end
      BK_LOOKUP: begin
        if (hit) begin
          wr_en      = 1'b1;
          wr_idx     = hit_idx;
          wr_count   = entry_frames[hit_idx] + 1'b1;
          res_en     = 1'b1;
          res_action = ACT_HIT;
          res_slot   = hit_idx;
          res_count  = wr_count;
        end else if (has_free) begin
          wr_en      = 1'b1;
          wr_fresh   = 1'b1;
          wr_idx     = IDX_W'(occupied);
          wr_count   = COUNT_W'(1);
          occ_inc    = 1'b1;
          res_en     = 1'b1;
          res_action = ACT_FREE;
          res_slot   = wr_idx;
          res_count  = wr_count;
          res_occ    = occupied + 1'b1;
        end else begin
          scan_start = 1'b1;
        end
      end
      BK_SCAN: scan_step = 1'b1;
      BK_WRITE: begin
        wr_en      = 1'b1;
        wr_fresh   = 1'b1;
        wr_idx     = best_idx;
        wr_count   = COUNT_W'(1);
        res_en     = 1'b1;
        res_action = ACT_EVICT;
        res_slot   = best_idx;
        res_count  = wr_count;
      end
      default: ;
    endcase
  end

  // table storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_frames[wr_idx]   <= wr_count;
      entry_strength[wr_idx] <= cur.rssi;
      entry_heard_at[wr_idx] <= cur.now_ms;
      if (wr_fresh) begin
        entry_address[wr_idx] <= cur.bssid;
      end
    end
  end

  // work item, oldest entry search, result payload
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_head;
    end
    if (scan_start) begin
      scan_idx  <= IDX_W'(1);
      best_idx  <= '0;
      best_time <= entry_heard_at[0];
    end else if (scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (scan_better) begin
        best_idx  <= scan_idx;
        best_time <= entry_heard_at[scan_idx];
      end
    end
    if (res_en) begin
      action       <= res_action;
      slot         <= SLOT_W'(res_slot);
      entry_count  <= res_count;
      frames_total <= total;
      entries_used <= USED_W'(res_occ);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      occupied <= '0;
      total    <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_en;
      if (take) begin
        total <= total + 1'b1;
      end
      if (occ_inc) begin
        occupied <= occupied + 1'b1;
      end
    end
  end

endmodule

@@ design/deauth_frame_source_tracker_core.sv @@
// top level of the deauth frame source tracker
`timescale 1ns / 1ps

// A frame is taken on a clock edge where start is high and busy is low; busy
// rises only when the two-entry input queue is full. Every frame yields one
// result, shown for a single cycle with done high, in input order; results
// cannot be held off by the receiver. An ignored frame is reported straight from
// the queue head by the table engine; a hit or a free-entry fill is dequeued,
// then compared and written back; an eviction also searches the oldest
// last-heard time one entry per cycle before the write. Nothing needs clearing
// after reset.
module deauth_frame_source_tracker_core import dfst_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     is_mgmt,
  input  logic [7:0]               frame_ctrl,
  input  logic [ADDR_W-1:0]        bssid,
  input  logic signed [RSSI_W-1:0] rssi,
  input  logic [TIME_W-1:0]        now_ms,
  output logic                     done,
  output logic [1:0]               action,
  output logic [SLOT_W-1:0]        slot,
  output logic [COUNT_W-1:0]       entry_count,
  output logic [TOTAL_W-1:0]       frames_total,
  output logic [USED_W-1:0]        entries_used
);

  logic        push;
  frame_item_t push_item;
  logic        pop;
  logic        q_valid;
  frame_item_t q_head;

  dfst_front u_front (
    .start      (start),
    .busy       (busy),
    .is_mgmt    (is_mgmt),
    .frame_ctrl (frame_ctrl),
    .bssid      (bssid),
    .rssi       (rssi),
    .now_ms     (now_ms),
    .push       (push),
    .item       (push_item)
  );

  dfst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (busy),
    .valid     (q_valid),
    .head      (q_head)
  );

  dfst_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .pop          (pop),
    .done         (done),
    .action       (action),
    .slot         (slot),
    .entry_count  (entry_count),
    .frames_total (frames_total),
    .entries_used (entries_used)
  );

  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    done && (action == ACT_IGNORED) |-> (slot == '0) && (entry_count == '0))
    else $error("ignored transaction reports a slot or count");

  a_new_entry_count: assert property (@(posedge clk) disable iff (rst)
    done && ((action == ACT_FREE) || (action == ACT_EVICT)) |-> (entry_count == 16'd1))
    else $error("new entry does not start at one");

  a_free_slot: assert property (@(posedge clk) disable iff (rst)
    done && (action == ACT_FREE) |-> (slot == entries_used - 3'd1))
    else $error("free entry taken out of order");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("dequeue from empty queue");

endmodule
